>>> rtl/ultrasonic_presence_detector_top_macros.svh
// Assertion macros for the ultrasonic presence detector.
// Used by ultrasonic_presence_detector_top; expects clk and rst_n in scope.
`ifndef ULTRASONIC_PRESENCE_DETECTOR_TOP_MACROS_SVH
`define ULTRASONIC_PRESENCE_DETECTOR_TOP_MACROS_SVH

// same-cycle implication
`define USPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define USPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// implication after a fixed number of cycles
`define USPD_ASSERT_DLY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) else $error(msg);

`endif

>>> rtl/uspd_pkg.sv
// Shared types and constants of the ultrasonic presence detector.
// No dependencies; imported by every module of the block.
package uspd_pkg;

  localparam int DIST_W    = 12;
  localparam int PCT_W     = 7;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam int WINDOW_LEN_DEF     = 16;
  localparam int WARMUP_SAMPLES_DEF = 100;

  // reference * percent, and its division by 100 through a reciprocal
  localparam int PROD_W       = DIST_W + PCT_W;
  localparam int PCT_SCALE    = 100;
  localparam int PCT_RECIP_SH = 26;
  localparam int PCT_RECIP_W  = 20;
  localparam logic [PCT_RECIP_W-1:0] PCT_RECIP =
    PCT_RECIP_W'(((64'd1 << PCT_RECIP_SH) + PCT_SCALE - 1) / PCT_SCALE);
  localparam int DELTA_W =
    $clog2((((1 << DIST_W) - 1) * ((1 << PCT_W) - 1)) / PCT_SCALE + 1);
  localparam int BAND_W  = DELTA_W + 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_BASIC,
    MODE_BASIC_AVG,
    MODE_SMART,
    MODE_SMART_AVG,
    MODE_PCT_BAND,
    MODE_CM_BAND
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETECT_MODE,
    CFG_THRESHOLD,
    CFG_NORMAL_DIST,
    CFG_REFERENCE_DIST,
    CFG_DEVIATION_PCT,
    CFG_DEVIATION_ABS
  } cfg_idx_t;

  typedef struct packed {
    logic [MODE_W-1:0] detect_mode;
    logic [DIST_W-1:0] threshold;
    logic [DIST_W-1:0] normal_distance;
    logic [DIST_W-1:0] reference_distance;
    logic [PCT_W-1:0]  deviation_pct;
    logic [DIST_W-1:0] deviation_abs;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    detect_mode:        3'd0,
    threshold:          12'd0,
    normal_distance:    12'd4095,
    reference_distance: 12'd0,
    deviation_pct:      7'd10,
    deviation_abs:      12'd0
  };

endpackage

>>> rtl/uspd_window.sv
// Sample window, running sum and warm-up counter of the presence detector.
// Depends on uspd_pkg. Window memory is prefetched at the oldest slot.
module uspd_window import uspd_pkg::*; #(
  parameter int WINDOW_LEN     = WINDOW_LEN_DEF,
  parameter int WARMUP_SAMPLES = WARMUP_SAMPLES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  input  logic [DIST_W-1:0]                     sample,
  output logic [DIST_W+$clog2(WINDOW_LEN)-1:0]  sum,
  output logic                                  item_ready
);

  localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SUM_W  = DIST_W + $clog2(WINDOW_LEN);
  localparam int WU_W   = (WARMUP_SAMPLES > 0) ? $clog2(WARMUP_SAMPLES + 1) : 1;

  logic [DIST_W-1:0] mem [WINDOW_LEN];
  logic [DIST_W-1:0] rd_data_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_inc;
  logic [SLOT_W-1:0] rd_addr;
  logic              filled_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [DIST_W-1:0] oldest;
  logic [WU_W-1:0]   wu_cnt_r;
  logic              warm_done;
  logic              item_ready_r;

  assign slot_inc  = (slot_r == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_r + 1'b1;
  // entries not yet written in the first pass read as zero
  assign oldest    = filled_r ? rd_data_r : '0;
  assign sum_nxt   = sum_r - SUM_W'(oldest) + SUM_W'(sample);
  assign rd_addr   = push ? slot_inc : slot_r;
  assign warm_done = (wu_cnt_r >= WU_W'(WARMUP_SAMPLES));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[slot_r] <= sample;
    end
    // forward the beat being written when the next slot is the same entry
    if (push && (rd_addr == slot_r)) begin
      rd_data_r <= sample;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r       <= '0;
      filled_r     <= 1'b0;
      sum_r        <= '0;
      wu_cnt_r     <= '0;
      item_ready_r <= 1'b0;
    end else if (push) begin
      slot_r       <= slot_inc;
      sum_r        <= sum_nxt;
      item_ready_r <= warm_done;
      if (slot_r == SLOT_W'(WINDOW_LEN - 1)) begin
        filled_r <= 1'b1;
      end
      if (!warm_done) begin
        wu_cnt_r <= wu_cnt_r + 1'b1;
      end
    end
  end

  assign sum        = sum_r;
  assign item_ready = item_ready_r;

endmodule

>>> rtl/uspd_decide.sv
// Detection decision of the presence detector: threshold and band checks.
// Depends on uspd_pkg; purely combinational.
module uspd_decide import uspd_pkg::*; (
  input  cfg_regs_t            cfg,
  input  logic [DIST_W-1:0]    raw,
  input  logic [DIST_W-1:0]    avg,
  input  logic [DELTA_W-1:0]   pct_delta,
  output logic                 detected
);

  logic [DELTA_W-1:0]       delta;
  logic signed [BAND_W-1:0] ref_s;
  logic signed [BAND_W-1:0] delta_s;
  logic signed [BAND_W-1:0] avg_s;
  logic signed [BAND_W-1:0] lo_s;
  logic signed [BAND_W-1:0] hi_s;
  logic                     outside;

  always_comb begin
    delta = (mode_t'(cfg.detect_mode) == MODE_CM_BAND) ? DELTA_W'(cfg.deviation_abs)
                                                       : pct_delta;
    ref_s   = $signed(BAND_W'(cfg.reference_distance));
    delta_s = $signed(BAND_W'(delta));
    avg_s   = $signed(BAND_W'(avg));
    // bounds are signed: a lower bound below zero never trips
    lo_s    = ref_s - delta_s;
    hi_s    = ref_s + delta_s;
    outside = (avg_s < lo_s) || (avg_s > hi_s) || (avg > cfg.normal_distance);
  end

  always_comb begin
    case (mode_t'(cfg.detect_mode))
      MODE_BASIC:     detected = (cfg.threshold < raw);
      MODE_BASIC_AVG: detected = (cfg.threshold < avg);
      MODE_SMART:     detected = (cfg.threshold < raw) || (raw > cfg.normal_distance);
      MODE_SMART_AVG: detected = (cfg.threshold < avg) || (avg > cfg.normal_distance);
      MODE_PCT_BAND:  detected = outside;
      MODE_CM_BAND:   detected = outside;
      default:        detected = 1'b0;
    endcase
  end

endmodule

>>> rtl/ultrasonic_presence_detector_top.sv
// Top level of the ultrasonic presence detector: config registers and pipeline.
// Depends on uspd_pkg, uspd_window, uspd_decide and the assertion macro header.
//
// Usage:
//   in_*   : one distance sample per beat, in_tdata[11:0] = distance_cm.
//   out_*  : one result per sample, in order. out_tdata[0] = detected,
//            out_tdata[12:1] = average_cm, out_tuser = ready_res.
//   cfg_*  : register write when cfg_we is high; cfg_index selects the register
//            (mode, threshold, normal distance, reference, percent, cm band).
// The path from input beat to result beat runs through the registered stages in
// order: the window update and reference product, the two reciprocal multiplies
// (average and percent band), then the decision into the output register. One
// sample is taken every cycle while in_tready is high; the running-sum update sets that rate.
// The first WARMUP_SAMPLES results carry ready_res low and detected low.
// Reset clears the window (it reads as zero until first written), the sum,
// the warm-up count and the registers to their defaults. When the receiver
// stalls, the output register holds its beat and the earlier stages keep
// filling; in_tready falls only when every stage is occupied.
`include "ultrasonic_presence_detector_top_macros.svh"

module ultrasonic_presence_detector_top import uspd_pkg::*; #(
  parameter int WINDOW_LEN     = WINDOW_LEN_DEF,
  parameter int WARMUP_SAMPLES = WARMUP_SAMPLES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // [11:0] distance_cm
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [0] detected, [12:1] average_cm
  output logic                   out_tuser,   // [0] ready_res
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int SUM_W      = DIST_W + $clog2(WINDOW_LEN);
  localparam int AVG_SH     = SUM_W + $clog2(WINDOW_LEN);
  localparam int AVG_K_W    = SUM_W + 1;
  localparam int AVG_PROD_W = SUM_W + AVG_K_W;
  localparam logic [AVG_K_W-1:0] AVG_K =
    AVG_K_W'(((64'd1 << AVG_SH) + WINDOW_LEN - 1) / WINDOW_LEN);
  localparam int PCT_PROD_W = PROD_W + PCT_RECIP_W;

  cfg_regs_t cfg_r;

  logic in_accept;
  logic rdy_o, rdy3, rdy2;
  logic mv23, mv3o;

  // stage 2: window state plus the sample and reference product
  logic               v2_r;
  logic [DIST_W-1:0]  raw2_r;
  logic [PROD_W-1:0]  prod2_r;
  logic [PROD_W-1:0]  prod_nxt;
  logic [SUM_W-1:0]   win_sum;
  logic               win_ready;

  // stage 3: average and percent band width
  logic                  v3_r;
  logic [DIST_W-1:0]     raw3_r;
  logic [DIST_W-1:0]     avg3_r;
  logic [DELTA_W-1:0]    delta3_r;
  logic                  ready3_r;
  logic [AVG_PROD_W-1:0] avg_prod;
  logic [PCT_PROD_W-1:0] pct_prod;

  // output register
  logic              vo_r;
  logic              det_r;
  logic              rdy_res_r;
  logic [DIST_W-1:0] avg_r;
  logic              decision;

  assign rdy_o     = !vo_r || out_tready;
  assign rdy3      = !v3_r || rdy_o;
  assign rdy2      = !v2_r || rdy3;
  assign in_tready = rdy2;
  assign in_accept = in_tvalid && in_tready;
  assign mv23      = v2_r && rdy3;
  assign mv3o      = v3_r && rdy_o;

  assign prod_nxt = PROD_W'(cfg_r.reference_distance) * PROD_W'(cfg_r.deviation_pct);
  assign avg_prod = AVG_PROD_W'(win_sum) * AVG_PROD_W'(AVG_K);
  assign pct_prod = PCT_PROD_W'(prod2_r) * PCT_PROD_W'(PCT_RECIP);

  uspd_window #(
    .WINDOW_LEN     (WINDOW_LEN),
    .WARMUP_SAMPLES (WARMUP_SAMPLES)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .sample     (in_tdata[DIST_W-1:0]),
    .sum        (win_sum),
    .item_ready (win_ready)
  );

  uspd_decide u_decide (
    .cfg       (cfg_r),
    .raw       (raw3_r),
    .avg       (avg3_r),
    .pct_delta (delta3_r),
    .detected  (decision)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DETECT_MODE:    cfg_r.detect_mode        <= cfg_wdata[MODE_W-1:0];
        CFG_THRESHOLD:      cfg_r.threshold          <= cfg_wdata[DIST_W-1:0];
        CFG_NORMAL_DIST:    cfg_r.normal_distance    <= cfg_wdata[DIST_W-1:0];
        CFG_REFERENCE_DIST: cfg_r.reference_distance <= cfg_wdata[DIST_W-1:0];
        CFG_DEVIATION_PCT:  cfg_r.deviation_pct      <= cfg_wdata[PCT_W-1:0];
        CFG_DEVIATION_ABS:  cfg_r.deviation_abs      <= cfg_wdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_r <= in_accept;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy_o) begin
        vo_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      raw2_r  <= in_tdata[DIST_W-1:0];
      prod2_r <= prod_nxt;
    end
    if (mv23) begin
      raw3_r   <= raw2_r;
      avg3_r   <= avg_prod[AVG_SH +: DIST_W];
      delta3_r <= pct_prod[PCT_RECIP_SH +: DELTA_W];
      ready3_r <= win_ready;
    end
    if (mv3o) begin
      // drop the detection during warm-up
      det_r     <= ready3_r && decision;
      rdy_res_r <= ready3_r;
      avg_r     <= avg3_r;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {(OUT_TDATA_W - DIST_W - 1)'(0), avg_r, det_r};
  assign out_tuser  = rdy_res_r;

  `USPD_ASSERT_DLY(a_fill_latency, in_accept && !v2_r && !v3_r && !vo_r, 3, out_tvalid, "result missing three cycles after beat into empty pipeline")
  `USPD_ASSERT_IMPL(a_warmup_quiet, out_tvalid && !out_tuser, !out_tdata[0], "detection flagged during warm-up")
  `USPD_ASSERT_IMPL(a_out_from_stage3, $rose(vo_r), $past(v3_r), "output beat appeared without a stage-3 item")
  `USPD_ASSERT_NEXT(a_warm_sticky, win_ready, win_ready, "warm-up state fell back")

endmodule

>>> tb/tb_ultrasonic_presence_detector_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for ultrasonic_presence_detector_top: stream driver, result
// monitor and a cycle-free predictor of the moving-average detector.
// Depends on uspd_pkg and the RTL of the block only.
module tb_ultrasonic_presence_detector_top;
  import uspd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int CHOKE_CYCLES   = 80;
  localparam int ITEM_TARGET    = 650;
  localparam int DIST_MAX       = (1 << DIST_W) - 1;
  localparam int PCT_MAX        = (1 << PCT_W) - 1;

  // register indexes past the list and mode codes with no meaning
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(CFG_DEVIATION_ABS + 1);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(CFG_DEVIATION_ABS + 2);
  localparam logic [MODE_W-1:0]    MODE_OFF_LO  = MODE_W'(MODE_CM_BAND + 1);
  localparam logic [MODE_W-1:0]    MODE_OFF_HI  = MODE_W'(MODE_CM_BAND + 2);

  typedef struct packed {
    logic              detected;
    logic              ready_res;
    logic [DIST_W-1:0] average_cm;
  } detection_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;    // [11:0] distance_cm
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [0] detected, [12:1] average_cm
  logic                   out_tuser;        // [0] ready_res
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  ultrasonic_presence_detector_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state and its copy of the registers
  logic [DIST_W-1:0]                   win_samples [WINDOW_LEN_DEF];
  logic [15:0]                         win_total = '0;
  logic [$clog2(WINDOW_LEN_DEF)-1:0]   next_slot = '0;
  int                                  samples_seen = 0;
  logic [MODE_W-1:0]                   cur_mode      = CFG_RESET.detect_mode;
  logic [DIST_W-1:0]                   cur_threshold = CFG_RESET.threshold;
  logic [DIST_W-1:0]                   cur_normal    = CFG_RESET.normal_distance;
  logic [DIST_W-1:0]                   cur_reference = CFG_RESET.reference_distance;
  logic [PCT_W-1:0]                    cur_pct       = CFG_RESET.deviation_pct;
  logic [DIST_W-1:0]                   cur_band_cm   = CFG_RESET.deviation_abs;

  logic [DIST_W-1:0] pending_samples [$];
  detection_t        expected_results [$];
  int samples_queued = 0;
  int samples_taken  = 0;
  int mismatches     = 0;
  int idle_cycles    = 0;
  int src_max_gap    = 10;
  int snk_max_gap    = 10;
  int src_gap        = 0;
  int snk_stall      = 0;
  int choke_left     = 0;
  bit choke_phase    = 1'b0;
  bit choke_done     = 1'b0;

  initial begin
    for (int i = 0; i < WINDOW_LEN_DEF; i++) win_samples[i] = '0;
  end

  // push one sample through the window and decide what the block reports for it
  function automatic detection_t judge_sample(input logic [DIST_W-1:0] meas_cm);
    detection_t r;
    int avg, raw, spread, lo, hi;
    logic hit, band_hit;
    win_total = win_total - win_samples[next_slot] + meas_cm;
    win_samples[next_slot] = meas_cm;
    next_slot = next_slot + 1'b1;
    r.average_cm = DIST_W'(win_total / WINDOW_LEN_DEF);
    r.ready_res  = (samples_seen >= WARMUP_SAMPLES_DEF);
    if (!r.ready_res) samples_seen++;
    avg = int'(r.average_cm);
    raw = int'(meas_cm);
    if (cur_mode == MODE_PCT_BAND) spread = (int'(cur_reference) * int'(cur_pct)) / PCT_SCALE;
    else spread = int'(cur_band_cm);
    lo = int'(cur_reference) - spread;
    hi = int'(cur_reference) + spread;
    band_hit = (avg < lo) || (avg > hi) || (avg > int'(cur_normal));
    case (cur_mode)
      MODE_BASIC:     hit = int'(cur_threshold) < raw;
      MODE_BASIC_AVG: hit = int'(cur_threshold) < avg;
      MODE_SMART:     hit = (int'(cur_threshold) < raw) || (raw > int'(cur_normal));
      MODE_SMART_AVG: hit = (int'(cur_threshold) < avg) || (avg > int'(cur_normal));
      MODE_PCT_BAND,
      MODE_CM_BAND:   hit = band_hit;
      default:        hit = 1'b0;
    endcase
    r.detected = r.ready_res && hit;
    return r;
  endfunction

  // mostly near a point of interest, with extremes and uniform noise mixed in
  function automatic logic [DIST_W-1:0] pick_distance(input int centre, input int span);
    int r, v;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return DIST_W'(DIST_MAX);
    if (r <= 4) return DIST_W'($urandom_range(0, DIST_MAX));
    v = centre + $signed($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > DIST_MAX) v = DIST_MAX;
    return DIST_W'(v);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_DETECT_MODE:    cur_mode      = val[MODE_W-1:0];
      CFG_THRESHOLD:      cur_threshold = val[DIST_W-1:0];
      CFG_NORMAL_DIST:    cur_normal    = val[DIST_W-1:0];
      CFG_REFERENCE_DIST: cur_reference = val[DIST_W-1:0];
      CFG_DEVIATION_PCT:  cur_pct       = val[PCT_W-1:0];
      CFG_DEVIATION_ABS:  cur_band_cm   = val[DIST_W-1:0];
      default: ;
    endcase
  endtask

  // narrow registers get random junk above their width
  task automatic apply_settings(input logic [MODE_W-1:0] mode, input logic [DIST_W-1:0] thr,
                                input logic [DIST_W-1:0] normal, input logic [DIST_W-1:0] refd,
                                input logic [PCT_W-1:0] pct, input logic [DIST_W-1:0] band);
    write_reg(CFG_DETECT_MODE, CFG_DATA_W'({$urandom(), mode}));
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_NORMAL_DIST, normal);
    write_reg(CFG_REFERENCE_DIST, refd);
    write_reg(CFG_DEVIATION_PCT, CFG_DATA_W'({$urandom(), pct}));
    write_reg(CFG_DEVIATION_ABS, band);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_DATA_W'($urandom()));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_sample(input logic [DIST_W-1:0] v);
    pending_samples.push_back(v);
    samples_queued++;
  endtask

  task automatic wait_drained();
    while (samples_taken != samples_queued || expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic feed_phase(input int count, input int centre, input int span);
    repeat (count) queue_sample(pick_distance(centre, span));
    wait_drained();
  endtask

  task automatic random_phase();
    int count, centre;
    logic [MODE_W-1:0] mode;
    logic [DIST_W-1:0] thr, normal, refd, band;
    logic [PCT_W-1:0]  pct;
    mode   = MODE_W'($urandom_range(0, (1 << MODE_W) - 1));
    thr    = DIST_W'($urandom_range(0, DIST_MAX));
    normal = $urandom_range(0, 1) ? DIST_W'(DIST_MAX) : DIST_W'($urandom_range(0, DIST_MAX));
    refd   = DIST_W'($urandom_range(0, DIST_MAX));
    pct    = PCT_W'($urandom_range(0, PCT_MAX));
    band   = DIST_W'($urandom_range(0, 1) ? $urandom_range(0, 400) : $urandom_range(0, DIST_MAX));
    apply_settings(mode, thr, normal, refd, pct, band);
    case ($urandom_range(0, 3))
      0:       centre = int'(thr);
      1:       centre = int'(normal);
      2:       centre = int'(refd) - int'(band);
      default: centre = int'(refd) + int'(band);
    endcase
    src_max_gap = $urandom_range(0, 2) == 0 ? 0 : 10;
    snk_max_gap = $urandom_range(0, 2) == 0 ? 0 : 10;
    count = $urandom_range(20, 40);
    feed_phase(count, centre, $urandom_range(30, 600));
  endtask

  // sender: hold each beat until taken, then idle for a drawn number of cycles
  always @(posedge clk) begin : sample_driver
    logic offer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      offer = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_results.push_back(judge_sample(in_tdata[DIST_W-1:0]));
        samples_taken++;
        offer = 1'b0;
        src_gap = $urandom_range(0, src_max_gap);
      end
      if (!offer) begin
        if (src_gap > 0) src_gap--;
        else if (pending_samples.size() != 0) begin
          in_tdata <= IN_TDATA_W'(pending_samples.pop_front());
          offer = 1'b1;
        end
      end
      in_tvalid <= offer;
    end
  end

  // receiver: random stalls after each beat, and one long hold-off when asked
  always @(posedge clk) begin : result_sink
    logic take;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (choke_phase && !choke_done) begin
        choke_done = 1'b1;
        choke_left = CHOKE_CYCLES;
      end
      if (choke_left > 0) begin
        choke_left--;
        take = 1'b0;
      end else begin
        if (out_tvalid && out_tready) snk_stall = $urandom_range(0, snk_max_gap);
        if (snk_stall > 0) begin
          snk_stall--;
          take = 1'b0;
        end else begin
          take = 1'b1;
        end
      end
      out_tready <= take;
    end
  end

  always @(posedge clk) begin : result_monitor
    detection_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: tdata %h tuser %b", out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[0] !== want.detected) begin
          $error("detected: expected %0d, got %0d", want.detected, out_tdata[0]);
          mismatches++;
        end
        if (out_tuser !== want.ready_res) begin
          $error("ready_res: expected %0d, got %0d", want.ready_res, out_tuser);
          mismatches++;
        end
        if (out_tdata[DIST_W:1] !== want.average_cm) begin
          $error("average_cm: expected %0d, got %0d", want.average_cm, out_tdata[DIST_W:1]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ultrasonic_presence_detector_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // warm-up with reset settings: full-scale window, then a crossing into ready results
    repeat (WINDOW_LEN_DEF) queue_sample(DIST_W'(DIST_MAX));
    queue_sample('0);
    queue_sample(DIST_W'(1));
    queue_sample(DIST_W'(DIST_MAX / 2 + 1));
    feed_phase(WARMUP_SAMPLES_DEF + 10 - (WINDOW_LEN_DEF + 3), DIST_MAX / 2, 2000);

    // every mode, with the registers at their extremes and at mid-range values
    apply_settings(MODE_BASIC, DIST_W'(DIST_MAX), '0, '0, '0, '0);
    feed_phase(12, DIST_MAX, 20);
    apply_settings(MODE_BASIC_AVG, DIST_W'(2000), DIST_W'(DIST_MAX), '0, '0, '0);
    feed_phase(16, 2000, 300);
    apply_settings(MODE_SMART, DIST_W'(DIST_MAX), '0, '0, '0, '0);
    feed_phase(10, 0, 3);
    apply_settings(MODE_SMART_AVG, DIST_W'(3000), DIST_W'(1000), '0, '0, '0);
    feed_phase(16, 1000, 400);
    // percent above 100 pushes the lower bound below zero
    apply_settings(MODE_PCT_BAND, '0, DIST_W'(DIST_MAX), DIST_W'(DIST_MAX), PCT_W'(PCT_MAX), '0);
    feed_phase(12, DIST_MAX, 100);
    apply_settings(MODE_PCT_BAND, '0, DIST_W'(DIST_MAX), '0, '0, '0);
    feed_phase(10, 0, 2);
    apply_settings(MODE_PCT_BAND, '0, DIST_W'(2400), DIST_W'(2000), PCT_W'(101), '0);
    feed_phase(16, 2300, 300);
    apply_settings(MODE_CM_BAND, '0, DIST_W'(DIST_MAX), DIST_W'(DIST_MAX), '0, DIST_W'(DIST_MAX));
    feed_phase(10, DIST_MAX, 50);
    apply_settings(MODE_CM_BAND, '0, DIST_W'(2050), DIST_W'(2000), '0, DIST_W'(100));
    feed_phase(16, 2000, 200);
    apply_settings(MODE_OFF_LO, '0, '0, '0, '0, '0);
    feed_phase(8, 2000, 2000);
    apply_settings(MODE_OFF_HI, '0, '0, '0, '0, '0);
    feed_phase(8, 2000, 2000);

    // back-pressure: fill the pipeline behind a long receiver hold-off
    src_max_gap = 0;
    snk_max_gap = 0;
    apply_settings(MODE_BASIC_AVG, DIST_W'(1500), DIST_W'(DIST_MAX), '0, '0, '0);
    choke_phase = 1'b1;
    feed_phase(40, 1500, 800);

    while (samples_queued < ITEM_TARGET) random_phase();

    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("ultrasonic_presence_detector_top regression: pass");
    end else begin
      $display("ultrasonic_presence_detector_top regression: fail");
    end
    $finish;
  end

endmodule
